FILE: hdl/smf_pkg.sv
`timescale 1ns / 1ps

package smf_pkg;

  // per-cycle control broadcast to every cell of the sorted row
  typedef struct packed {
    logic upd;   // an item is taken this cycle
    logic full;  // window full, the oldest entry leaves
  } smf_ctrl_t;

endpackage

FILE: hdl/sliding_median_filter.sv
`timescale 1ns / 1ps

// Sliding-window median filter. Each item on the input carries one unsigned
// sample; the block returns one item per sample holding the lower median of
// the last WINDOW_DEPTH samples (fewer while the window fills after reset).
// The window is kept sorted in a row of WINDOW_DEPTH cells: each accepted
// sample drops the oldest entry once the window is full and is inserted at
// its sorted place in the registered row, and the result is then copied from
// the middle cell into the output register once that register is free. One
// item per cycle is sustained while the output side takes results.
module sliding_median_filter
  import smf_pkg::*;
#(
  parameter int WINDOW_DEPTH = 16,
  parameter int SAMPLE_BITS  = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,   // [SAMPLE_BITS-1:0] sample
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]    out_tdata   // [SAMPLE_BITS-1:0] median
);

  localparam int DW = SAMPLE_BITS;
  localparam int TW = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam logic [CW-1:0] Depth = CW'(WINDOW_DEPTH);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] mid_r;
  logic          pend_r;
  logic          out_valid_r;
  logic [DW-1:0] out_data_r;

  smf_ctrl_t     ctrl;
  logic          acc, load;
  logic [CW-1:0] keep_cnt;
  logic [CW-1:0] mid_full;
  logic [DW-1:0] sample;

  logic [DW-1:0] val  [WINDOW_DEPTH];
  logic [DW-1:0] cval [WINDOW_DEPTH];
  logic [AW-1:0] cage [WINDOW_DEPTH];
  logic          le   [WINDOW_DEPTH];
  logic          rm   [WINDOW_DEPTH];
  // held age of each cell, seen by the lower neighbor when closing a gap
  logic [AW-1:0] cage_raw [WINDOW_DEPTH];

  assign sample    = in_tdata[DW-1:0];
  assign load      = pend_r && (!out_valid_r || out_tready);
  assign in_tready = !pend_r || load;
  assign acc       = in_tvalid && in_tready;

  assign ctrl.upd  = acc;
  assign ctrl.full = (cnt_r == Depth);
  assign keep_cnt  = ctrl.full ? Depth - CW'(1) : cnt_r;
  assign cnt_nxt   = ctrl.full ? Depth : cnt_r + CW'(1);
  assign mid_full  = (cnt_nxt - CW'(1)) >> 1;

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    logic [DW-1:0] up_val;
    logic [AW-1:0] up_age;
    logic          rm_in;
    logic [DW-1:0] lo_cval;
    logic [AW-1:0] lo_cage;
    logic          lo_le;

    if (i == WINDOW_DEPTH - 1) begin : g_top
      assign up_val = val[i];
      assign up_age = '0;
    end else begin : g_mid
      assign up_val = val[i+1];
      assign up_age = cage_raw[i+1];
    end

    if (i == 0) begin : g_bot
      assign rm_in   = 1'b0;
      assign lo_cval = sample;
      assign lo_cage = '0;
      assign lo_le   = 1'b0;
    end else begin : g_up
      assign rm_in   = rm[i-1];
      assign lo_cval = cval[i-1];
      assign lo_cage = cage[i-1];
      assign lo_le   = le[i-1];
    end

    smf_cell #(
      .DEPTH (WINDOW_DEPTH),
      .DW    (DW),
      .AW    (AW),
      .CW    (CW),
      .IDX   (i)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .keep_cnt (keep_cnt),
      .sample   (sample),
      .up_val   (up_val),
      .up_age   (up_age),
      .rm_in    (rm_in),
      .lo_cval  (lo_cval),
      .lo_cage  (lo_cage),
      .lo_le    (lo_le),
      .rm_out   (rm[i]),
      .cval     (cval[i]),
      .cage     (cage[i]),
      .le       (le[i]),
      .val      (val[i]),
      .age      (cage_raw[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        cnt_r  <= cnt_nxt;
        mid_r  <= mid_full[AW-1:0];
      end
      if (acc) begin
        pend_r <= 1'b1;
      end else if (load) begin
        pend_r <= 1'b0;
      end
      if (load) begin
        out_valid_r <= 1'b1;
        out_data_r  <= val[mid_r];
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TW'(out_data_r);

endmodule

FILE: hdl/smf_cell.sv
`timescale 1ns / 1ps

module smf_cell
  import smf_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int DW    = 12,
  parameter int AW    = 4,
  parameter int CW    = 5,
  parameter int IDX   = 0
) (
  input  logic          clk,
  input  smf_ctrl_t     ctrl,
  input  logic [CW-1:0] keep_cnt,  // entries left after removal
  input  logic [DW-1:0] sample,
  input  logic [DW-1:0] up_val,    // upper neighbor, held value
  input  logic [AW-1:0] up_age,
  input  logic          rm_in,     // removal at or below lower neighbor
  input  logic [DW-1:0] lo_cval,   // lower neighbor, compacted value
  input  logic [AW-1:0] lo_cage,
  input  logic          lo_le,
  output logic          rm_out,
  output logic [DW-1:0] cval,
  output logic [AW-1:0] cage,
  output logic          le,
  output logic [DW-1:0] val,
  output logic [AW-1:0] age
);

  localparam logic [AW-1:0] AgeMax = AW'(DEPTH - 1);
  localparam logic [CW-1:0] Pos    = CW'(IDX);

  logic [DW-1:0] val_r, val_nxt;
  logic [AW-1:0] age_r, age_nxt;
  logic          rm_here;

  // the oldest entry carries the top age once the window is full
  assign rm_here = ctrl.full && (age_r == AgeMax);
  assign rm_out  = rm_in || rm_here;

  // close the gap left by the removed entry
  assign cval = rm_out ? up_val : val_r;
  assign cage = rm_out ? up_age : age_r;
  assign le   = (Pos < keep_cnt) && (cval <= sample);

  always_comb begin
    if (le) begin
      val_nxt = cval;
      age_nxt = cage + AW'(1);
    end else if (IDX == 0 || lo_le) begin
      val_nxt = sample;
      age_nxt = '0;
    end else begin
      val_nxt = lo_cval;
      age_nxt = lo_cage + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.upd) begin
      val_r <= val_nxt;
      age_r <= age_nxt;
    end
  end

  assign val = val_r;
  assign age = age_r;

endmodule

FILE: hdl/smf_checker.sv
`timescale 1ns / 1ps

module smf_checker #(
  parameter int WINDOW_DEPTH = 16,
  parameter int SAMPLE_BITS  = 12
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [((SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [((SAMPLE_BITS+7)/8)*8-1:0] out_tdata
);

  logic       in_acc, out_acc;
  logic [1:0] open_r;
  logic       first_in_r, first_out_r;
  logic [SAMPLE_BITS-1:0] first_smp_r;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r      <= '0;
      first_in_r  <= 1'b1;
      first_out_r <= 1'b1;
    end else begin
      if (in_acc && !out_acc) begin
        open_r <= open_r + 2'd1;
      end else if (!in_acc && out_acc) begin
        open_r <= open_r - 2'd1;
      end
      if (in_acc) begin
        first_in_r  <= 1'b0;
        if (first_in_r) begin
          first_smp_r <= in_tdata[SAMPLE_BITS-1:0];
        end
      end
      if (out_acc) begin
        first_out_r <= 1'b0;
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    open_r != 2'd3)
    else $error("too many items in flight");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    open_r == 2'd0 |-> !out_tvalid)
    else $error("result without an item");

  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && first_out_r && !first_in_r |->
      out_tdata[SAMPLE_BITS-1:0] == first_smp_r)
    else $error("first median differs from first sample");

endmodule

bind sliding_median_filter smf_checker #(
  .WINDOW_DEPTH (WINDOW_DEPTH),
  .SAMPLE_BITS  (SAMPLE_BITS)
) u_smf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: dv/tb_sliding_median_filter.sv
`timescale 1ns / 1ps

class median_scoreboard #(int DEPTH = 16, int BITS = 12);
  logic [BITS-1:0] window [DEPTH];
  int unsigned     held;
  int unsigned     oldest_slot;
  logic [BITS-1:0] expected_medians[$];
  int unsigned     errors;
  int unsigned     checked;
  int unsigned     wraps;

  function new();
    held        = 0;
    oldest_slot = 0;
    errors      = 0;
    checked     = 0;
    wraps       = 0;
  endfunction

  // insert the sample, then take the lower median of what is held
  function void note_sample(logic [BITS-1:0] sample);
    logic [BITS-1:0] sorted [DEPTH];
    logic [BITS-1:0] v;
    int              i;
    int              j;
    if (held < DEPTH) begin
      window[held] = sample;
      held++;
    end else begin
      window[oldest_slot] = sample;
      oldest_slot = (oldest_slot + 1) % DEPTH;
      if (oldest_slot == 0) wraps++;
    end
    for (i = 0; i < held; i++) begin
      v = window[i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    expected_medians.insert(expected_medians.size(), sorted[(held - 1) / 2]);
  endfunction

  function void check_median(logic [BITS-1:0] got);
    logic [BITS-1:0] want;
    if (expected_medians.size() == 0) begin
      errors++;
      if (errors <= 100) $display("%0t: unexpected median item %0d", $time, got);
      return;
    end
    want = expected_medians[0];
    expected_medians.delete(0);
    checked++;
    if (got !== want) begin
      errors++;
      if (errors <= 100)
        $display("%0t: median mismatch expected %0d actual %0d", $time, want, got);
    end
  endfunction

  function int unsigned pending();
    return expected_medians.size();
  endfunction
endclass

module tb_sliding_median_filter;
  localparam int DEPTH     = 16;
  localparam int BITS      = 12;
  localparam int TDATA_W   = ((BITS + 7) / 8) * 8;
  localparam logic [BITS-1:0] MAX_VAL = '1;
  localparam int N_RANDOM  = 1530;
  localparam int CYCLE_CAP = 400000;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata;
  logic               out_tvalid;
  logic               out_tready;
  logic [TDATA_W-1:0] out_tdata;

  median_scoreboard #(DEPTH, BITS) sb;

  int unsigned cycles;
  int unsigned sent;
  int unsigned in_burst;
  int unsigned out_burst;

  sliding_median_filter #(
    .WINDOW_DEPTH(DEPTH),
    .SAMPLE_BITS (BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("%0t: timeout", $time);
      $display("tb_sliding_median_filter: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_sample(in_tdata[BITS-1:0]);
    if (rst_n && out_tvalid && out_tready) sb.check_median(out_tdata[BITS-1:0]);
  end

  // gap before the next item; bursts give stretches without idling
  function automatic int unsigned draw_gap(ref int unsigned burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  task automatic send_sample(input logic [BITS-1:0] sample);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tdata  <= TDATA_W'(sample);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
    gap = draw_gap(in_burst);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int unsigned stall;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      stall = draw_gap(out_burst);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin
    logic [BITS-1:0] directed[$];
    int              kind;
    int              len;
    int              base;
    int              step;
    int              i;
    int              k;
    sb         = new();
    cycles     = 0;
    sent       = 0;
    in_burst   = 0;
    out_burst  = 0;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    out_tready <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // filling with extremes and even counts, duplicates, then wrap of the window
    directed = '{MAX_VAL, 0, MAX_VAL, 0, 2048, 2048, 2048, 1, MAX_VAL - 1, 12'h555,
                 12'hAAA, 7, 7, 7, MAX_VAL, 0, 0, 0, MAX_VAL, MAX_VAL, 12'h800, 12'h7FF};
    foreach (directed[j]) send_sample(directed[j]);

    i = 0;
    while (i < N_RANDOM) begin
      kind = $urandom_range(0, 5);
      len  = $urandom_range(4, 40);
      base = $urandom_range(0, MAX_VAL);
      step = $urandom_range(1, 200);
      for (k = 0; k < len && i < N_RANDOM; k++) begin
        case (kind)
          0, 1: send_sample(BITS'($urandom_range(0, MAX_VAL)));
          2: send_sample(BITS'(base + $urandom_range(0, 7)));
          3: send_sample($urandom_range(0, 1) ? BITS'(MAX_VAL) : BITS'(0));
          4: send_sample(BITS'(base + k * step));
          default: send_sample(BITS'(base - k * step));
        endcase
        i++;
      end
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d samples driven, %0d medians checked, window wrapped %0d times",
             sent, sb.checked, sb.wraps);
    $display("stimulus: filling phase, extremes, duplicates, ramps and random runs");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_sliding_median_filter: clean");
    end else begin
      $display("tb_sliding_median_filter: errors");
    end
    $finish;
  end
endmodule
